// ----- src/ttce_pkg.sv -----
// shared constants, types and helpers of the text terminal character engine
package ttce_pkg;

    localparam int GRID_ROWS = 24;
    localparam int GRID_COLS = 80;
    localparam int CELLS     = GRID_ROWS * GRID_COLS;

    localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int ROW_W1 = ROW_W + 1;
    localparam int COL_W1 = COL_W + 1;
    localparam int ADDR_W = $clog2(CELLS);

    // byte codes of the interpreter
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0a;
    localparam logic [7:0] CH_CR        = 8'h0d;
    localparam logic [7:0] CH_ESC       = 8'h1b;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_LBRACKET  = 8'h5b;
    localparam logic [7:0] CH_DEL       = 8'h7f;
    localparam logic [7:0] CSI_FINAL_LO = 8'h40;
    localparam logic [7:0] CSI_FINAL_HI = 8'h7e;
    localparam int         TAB_STEP     = 8;

    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        ESC_NORMAL = 2'd0,
        ESC_SEEN   = 2'd1,
        ESC_CSI    = 2'd2
    } t_esc;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_EMIT
    } t_state;

    // next cursor and escape state, write enable and scroll flag for one fed byte
    typedef struct packed {
        t_esc             esc;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             we;
        logic             scroll;
    } t_dec;

    typedef struct packed {
        logic       did_scroll;
        logic [1:0] escape_mode;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [6:0] cell_char;
    } t_result;

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                 input logic [ROW_W-1:0] vis);
        logic [ROW_W1-1:0] sum;
        sum = {1'b0, top} + {1'b0, vis};
        if (sum >= ROW_W1'(GRID_ROWS)) begin
            sum = sum - ROW_W1'(GRID_ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
        return ADDR_W'(32'(prow) * GRID_COLS + 32'(col));
    endfunction

endpackage

// ----- src/ttce_decode.sv -----
// byte interpreter: escape tracking and cursor movement for one fed byte
module ttce_decode (
    input  logic [7:0]                  i_byte,
    input  ttce_pkg::t_esc              i_esc,
    input  logic [ttce_pkg::ROW_W-1:0]  i_row,
    input  logic [ttce_pkg::COL_W-1:0]  i_col,
    output ttce_pkg::t_dec              o_dec
);

    logic [ttce_pkg::COL_W1-1:0] tab_col;
    logic                        printable;

    assign printable = (i_byte >= ttce_pkg::CH_SPACE) && (i_byte < ttce_pkg::CH_DEL);

    always_comb begin
        tab_col = {1'b0, i_col} + ttce_pkg::COL_W1'(ttce_pkg::TAB_STEP);
        tab_col = tab_col & ~ttce_pkg::COL_W1'(ttce_pkg::TAB_STEP - 1);
    end

    always_comb begin
        o_dec.esc    = i_esc;
        o_dec.row    = i_row;
        o_dec.col    = i_col;
        o_dec.we     = 1'b0;
        o_dec.scroll = 1'b0;
        unique case (i_esc)
            ttce_pkg::ESC_SEEN: begin
                o_dec.esc = (i_byte == ttce_pkg::CH_LBRACKET) ? ttce_pkg::ESC_CSI
                                                              : ttce_pkg::ESC_NORMAL;
            end
            ttce_pkg::ESC_CSI: begin
                if (i_byte >= ttce_pkg::CSI_FINAL_LO && i_byte <= ttce_pkg::CSI_FINAL_HI) begin
                    o_dec.esc = ttce_pkg::ESC_NORMAL;
                end
            end
            default: begin
                o_dec.esc = ttce_pkg::ESC_NORMAL;
                unique case (i_byte)
                    ttce_pkg::CH_ESC: o_dec.esc = ttce_pkg::ESC_SEEN;
                    ttce_pkg::CH_CR:  o_dec.col = '0;
                    ttce_pkg::CH_LF: begin
                        o_dec.col = '0;
                        if (i_row == ttce_pkg::ROW_W'(ttce_pkg::GRID_ROWS - 1)) begin
                            o_dec.scroll = 1'b1;
                        end else begin
                            o_dec.row = i_row + 1'b1;
                        end
                    end
                    ttce_pkg::CH_BS: begin
                        if (i_col != '0) begin
                            o_dec.col = i_col - 1'b1;
                        end
                    end
                    ttce_pkg::CH_TAB: begin
                        if (tab_col >= ttce_pkg::COL_W1'(ttce_pkg::GRID_COLS)) begin
                            o_dec.col = ttce_pkg::COL_W'(ttce_pkg::GRID_COLS - 1);
                        end else begin
                            o_dec.col = tab_col[ttce_pkg::COL_W-1:0];
                        end
                    end
                    ttce_pkg::CH_BEL: o_dec.we = 1'b0;
                    default: begin
                        if (printable) begin
                            o_dec.we = 1'b1;
                            // wrap to a new line after the last column
                            if (i_col == ttce_pkg::COL_W'(ttce_pkg::GRID_COLS - 1)) begin
                                o_dec.col = '0;
                                if (i_row == ttce_pkg::ROW_W'(ttce_pkg::GRID_ROWS - 1)) begin
                                    o_dec.scroll = 1'b1;
                                end else begin
                                    o_dec.row = i_row + 1'b1;
                                end
                            end else begin
                                o_dec.col = i_col + 1'b1;
                            end
                        end
                    end
                endcase
            end
        endcase
    end

endmodule

// ----- src/text_terminal_char_engine.sv -----
// top level of the text terminal character engine: grid store, cursor and item flow
//
// usage: a slave stream carries commands, a master stream carries one result per item.
// s_tuser selects the command: 0 feeds s_tdata's byte to the terminal interpreter,
// 1 reads the cell at the given visible row and column. every item yields one result
// holding the cell character (0 for a feed or an out-of-range read), the cursor after
// the item, the escape mode and a flag telling that the feed scrolled the grid.
// the grid is one 1920 x 7 bit synchronous memory; scrolling moves a top-row offset
// and clears the new bottom row through the memory's single write port.
// item flow:
//   ordinary feed: result registered the cycle after accept, one item per cycle while the receiver keeps up
//   read: memory read, then result; no new item is taken meanwhile
//   scrolling feed: the GRID_COLS (80 here) cells of the new bottom row are cleared, then the result
// reset (synchronous, active low) starts a clearing pass that writes a space to each
// of the 1920 cells, one per cycle; s_tready stays low for those cycles.
// when the receiver stalls the result waits in the output register; one more item
// is taken meanwhile and parked, after which s_tready drops until the output drains.
module text_terminal_char_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], read_row[12:8], read_col[19:13], zero pad
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // cell_char[6:0], cursor_row[11:7], cursor_col[18:12],
                                   // escape_mode[20:19], did_scroll[21], zero pad
);

    // input fields
    logic                          in_cmd;
    logic [7:0]                    in_byte;
    logic [4:0]                    in_read_row;
    logic [6:0]                    in_read_col;

    // state
    ttce_pkg::t_state              r_state, n_state;
    logic [ttce_pkg::ROW_W-1:0]    r_top;
    logic [ttce_pkg::ROW_W-1:0]    r_row;
    logic [ttce_pkg::COL_W-1:0]    r_col;
    ttce_pkg::t_esc                r_esc;
    logic [ttce_pkg::ADDR_W-1:0]   r_clr_addr;
    logic [ttce_pkg::ADDR_W-1:0]   r_clr_last;
    logic [6:0]                    r_mem [ttce_pkg::CELLS];
    logic [6:0]                    r_rd_data;
    ttce_pkg::t_result             r_pend;
    ttce_pkg::t_result             r_out;
    logic                          r_out_valid;

    // control
    ttce_pkg::t_dec                dec;
    ttce_pkg::t_result             cur_res;
    ttce_pkg::t_result             res_now;
    logic                          accept;
    logic                          out_free;
    logic                          in_range;
    logic                          need_read;
    logic                          do_scroll;
    logic                          clr_done;
    logic                          out_load;
    logic                          mem_we;
    logic [ttce_pkg::ADDR_W-1:0]   mem_waddr;
    logic [6:0]                    mem_wdata;
    logic [ttce_pkg::ADDR_W-1:0]   rd_addr;
    logic [ttce_pkg::ADDR_W-1:0]   scroll_base;
    logic [ttce_pkg::ROW_W-1:0]    top_next;

    assign in_cmd      = s_tuser[0];
    assign in_byte     = s_tdata[7:0];
    assign in_read_row = s_tdata[12:8];
    assign in_read_col = s_tdata[19:13];

    assign accept   = s_tvalid && s_tready;
    assign out_free = !r_out_valid || m_tready;
    assign clr_done = (r_clr_addr == r_clr_last);

    assign in_range  = (32'(in_read_row) < ttce_pkg::GRID_ROWS) &&
                       (32'(in_read_col) < ttce_pkg::GRID_COLS);
    assign need_read = (in_cmd == ttce_pkg::CMD_READ) && in_range;
    assign do_scroll = (in_cmd == ttce_pkg::CMD_FEED) && dec.scroll;

    ttce_decode u_decode (
        .i_byte (in_byte),
        .i_esc  (r_esc),
        .i_row  (r_row),
        .i_col  (r_col),
        .o_dec  (dec)
    );

    // addresses: visible row goes through the top-row offset
    assign rd_addr   = ttce_pkg::cell_addr(ttce_pkg::phys_row(r_top, ttce_pkg::ROW_W'(in_read_row)),
                                           ttce_pkg::COL_W'(in_read_col));
    assign scroll_base = ttce_pkg::cell_addr(r_top, '0);
    assign top_next  = (r_top == ttce_pkg::ROW_W'(ttce_pkg::GRID_ROWS - 1)) ? '0 : r_top + 1'b1;

    // result of the item offered this cycle, cell char filled in later for reads
    always_comb begin
        cur_res             = '0;
        cur_res.escape_mode = (in_cmd == ttce_pkg::CMD_FEED) ? dec.esc : r_esc;
        cur_res.cursor_row  = 5'((in_cmd == ttce_pkg::CMD_FEED) ? dec.row : r_row);
        cur_res.cursor_col  = 7'((in_cmd == ttce_pkg::CMD_FEED) ? dec.col : r_col);
        cur_res.did_scroll  = do_scroll;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ttce_pkg::ST_INIT: begin
                if (clr_done) n_state = ttce_pkg::ST_IDLE;
            end
            ttce_pkg::ST_IDLE: begin
                if (accept) begin
                    priority if (need_read) n_state = ttce_pkg::ST_READ;
                    else if (do_scroll)     n_state = ttce_pkg::ST_SCROLL;
                    else if (!out_free)     n_state = ttce_pkg::ST_EMIT;
                    else                    n_state = ttce_pkg::ST_IDLE;
                end
            end
            ttce_pkg::ST_READ: begin
                n_state = out_free ? ttce_pkg::ST_IDLE : ttce_pkg::ST_EMIT;
            end
            ttce_pkg::ST_SCROLL: begin
                if (clr_done) n_state = out_free ? ttce_pkg::ST_IDLE : ttce_pkg::ST_EMIT;
            end
            ttce_pkg::ST_EMIT: begin
                if (out_free) n_state = ttce_pkg::ST_IDLE;
            end
            default: n_state = ttce_pkg::ST_INIT;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = 1'b0;
        out_load  = 1'b0;
        res_now   = r_pend;
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = ttce_pkg::CH_SPACE[6:0];
        unique case (r_state)
            ttce_pkg::ST_INIT: begin
                mem_we = 1'b1;
            end
            ttce_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                res_now   = cur_res;
                out_load  = accept && !need_read && !do_scroll && out_free;
                mem_we    = accept && (in_cmd == ttce_pkg::CMD_FEED) && dec.we;
                mem_waddr = ttce_pkg::cell_addr(ttce_pkg::phys_row(r_top, r_row), r_col);
                mem_wdata = in_byte[6:0];
            end
            ttce_pkg::ST_READ: begin
                res_now.cell_char = r_rd_data;
                out_load          = out_free;
            end
            ttce_pkg::ST_SCROLL: begin
                mem_we   = 1'b1;
                out_load = clr_done && out_free;
            end
            ttce_pkg::ST_EMIT: begin
                out_load = out_free;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttce_pkg::ST_INIT;
            r_top       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_esc       <= ttce_pkg::ESC_NORMAL;
            r_clr_addr  <= '0;
            r_clr_last  <= ttce_pkg::ADDR_W'(ttce_pkg::CELLS - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && (in_cmd == ttce_pkg::CMD_FEED)) begin
                r_row <= dec.row;
                r_col <= dec.col;
                r_esc <= dec.esc;
            end
            // the old top row becomes the new bottom row and is swept to spaces
            if (accept && do_scroll) begin
                r_top      <= top_next;
                r_clr_addr <= scroll_base;
                r_clr_last <= scroll_base + ttce_pkg::ADDR_W'(ttce_pkg::GRID_COLS - 1);
            end else if ((r_state == ttce_pkg::ST_INIT || r_state == ttce_pkg::ST_SCROLL)
                         && !clr_done) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= cur_res;
        end else if (r_state == ttce_pkg::ST_READ) begin
            // keep the read character with the parked result if the output is still busy
            r_pend.cell_char <= r_rd_data;
        end
        if (out_load) begin
            r_out <= res_now;
        end
    end

    // grid store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (accept && need_read) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_out};

`ifndef SYNTHESIS
    // a waiting result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_tready) |-> !out_load)
        else $error("result register overwritten while stalled");

    // a clearing sweep never runs past its last cell
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttce_pkg::ST_INIT || r_state == ttce_pkg::ST_SCROLL)
        |-> (r_clr_addr <= r_clr_last))
        else $error("clearing sweep out of bounds");

    // cursor and top offset stay on the grid
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < ttce_pkg::GRID_ROWS) && (32'(r_col) < ttce_pkg::GRID_COLS)
        && (32'(r_top) < ttce_pkg::GRID_ROWS))
        else $error("cursor or top offset off the grid");

    // a scrolling feed advances the top offset by one row
    a_scroll_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && do_scroll) |=> (r_top == $past(top_next)) && (r_state == ttce_pkg::ST_SCROLL))
        else $error("scroll did not advance the top row");
`endif

endmodule
